### hw/rtl/node_registry_table_macros.svh
// Assertion macros for the node registry table top level.
`ifndef NODE_REGISTRY_TABLE_MACROS_SVH
`define NODE_REGISTRY_TABLE_MACROS_SVH
`ifndef SYNTHESIS
`define NRT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`define NRT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define NRT_ASSERT(lbl, prop, msg)
`define NRT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### hw/rtl/nrt_pkg.sv
// Package with sizes, codes, types and helpers of the node registry table.
`default_nettype none
package nrt_pkg;
    localparam int DEPTH    = 16;
    localparam int SLOT_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int KEY_W    = 48;
    localparam int TIME_W   = 32;
    localparam int ID_W     = 8;
    localparam int CMD_W    = 3;
    localparam int STATUS_W = 2;
    localparam int RID_W    = 5;
    localparam int OCNT_W   = 5;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd300000;

    localparam logic [APB_AW-3:0] REG_TIMEOUT = 1'b0;

    localparam logic [CMD_W-1:0] CMD_REGISTER = 3'd0;
    localparam logic [CMD_W-1:0] CMD_CHECK    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_TOUCH    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_FIND     = 3'd3;
    localparam logic [CMD_W-1:0] CMD_COUNT    = 3'd4;
    localparam logic [CMD_W-1:0] CMD_READ     = 3'd5;

    localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_ADDED   = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_MISS    = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_INVALID = 2'd3;

    typedef struct packed {
        logic              vld;
        logic [KEY_W-1:0]  key;
        logic [TIME_W-1:0] now;
        logic [SLOT_W-1:0] sel;
        logic              hit;
        logic [SLOT_W-1:0] hit_idx;
        logic              free;
        logic [SLOT_W-1:0] free_idx;
        logic [CNT_W-1:0]  cnt;
        logic              rd_act;
        logic [KEY_W-1:0]  rd_key;
        logic [TIME_W-1:0] rd_ls;
    } nrt_token_t;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] idx;
        logic              set_valid;
        logic [KEY_W-1:0]  key;
        logic [TIME_W-1:0] now;
    } nrt_write_t;

    function automatic logic [RID_W-1:0] slot_to_id(input logic [SLOT_W-1:0] slot);
        logic [ID_W-1:0] wide;
        wide = ID_W'(slot) + ID_W'(1);
        return wide[RID_W-1:0];
    endfunction

    function automatic logic [OCNT_W-1:0] cnt_to_out(input logic [CNT_W-1:0] cnt);
        logic [ID_W-1:0] wide;
        wide = ID_W'(cnt);
        return wide[OCNT_W-1:0];
    endfunction
endpackage
`default_nettype wire

### hw/rtl/nrt_cell.sv
// One slot of the table: holds its entry and updates the query item passing by.
`default_nettype none
module nrt_cell import nrt_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [SLOT_W-1:0] cell_idx,
    input  logic [TIME_W-1:0] timeout,
    input  nrt_write_t        wr,
    input  nrt_token_t        tok_in,
    output nrt_token_t        tok_out
);
    logic              valid_reg, valid_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [TIME_W-1:0] ls_reg, ls_next;
    nrt_token_t        tok_reg, tok_next;
    logic [TIME_W-1:0] age;

    always_comb begin
        tok_next = tok_in;
        age = tok_in.now - ls_reg;
        if (!tok_in.hit && valid_reg && (key_reg == tok_in.key)) begin
            tok_next.hit     = 1'b1;
            tok_next.hit_idx = cell_idx;
        end
        if (!tok_in.free && !valid_reg) begin
            tok_next.free     = 1'b1;
            tok_next.free_idx = cell_idx;
        end
        if (valid_reg && (age < timeout)) begin
            tok_next.cnt = tok_in.cnt + CNT_W'(1);
        end
        if (tok_in.sel == cell_idx) begin
            tok_next.rd_act = valid_reg;
            tok_next.rd_key = key_reg;
            tok_next.rd_ls  = ls_reg;
        end
    end

    always_comb begin
        valid_next = valid_reg;
        key_next   = key_reg;
        ls_next    = ls_reg;
        if (wr.en && (wr.idx == cell_idx)) begin
            ls_next = wr.now;
            if (wr.set_valid) begin
                valid_next = 1'b1;
                key_next   = wr.key;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            ls_reg    <= '0;
            tok_reg   <= '0;
        end else begin
            valid_reg <= valid_next;
            ls_reg    <= ls_next;
            tok_reg   <= tok_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg <= key_next;
    end

    assign tok_out = tok_reg;
endmodule
`default_nettype wire

### hw/rtl/node_registry_table.sv
// Top level of the node registry table: command control, register port and cell chain.
//
//   Port group   Dir   Handshake          Carries
//   s_*          in    s_valid/s_ready    command, node_key, node_id, now_ms
//   m_*          out   m_valid/m_ready    status, result_id, flags, count, slot data
//   APB          in    psel/penable       offline_timeout at byte address 0
//
// Every item walks the chain of DEPTH slot cells, one cell per cycle; its result is
// registered in the result registers and then moved to the output register.
// Writes from register and touch are applied when the item leaves the last cell.
// A new item is accepted once the previous result has moved to the output register.
// Reset is synchronous and clears the slot valid bits and last-seen times at once.
`default_nettype none
`include "node_registry_table_macros.svh"
module node_registry_table import nrt_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [APB_AW-1:0]   paddr,
    input  logic [APB_DW-1:0]   pwdata,
    output logic [APB_DW-1:0]   prdata,
    output logic                pready,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [CMD_W-1:0]    s_command,
    input  logic [KEY_W-1:0]    s_node_key,
    input  logic [ID_W-1:0]     s_node_id,
    input  logic [TIME_W-1:0]   s_now_ms,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [STATUS_W-1:0] m_status,
    output logic [RID_W-1:0]    m_result_id,
    output logic                m_active_flag,
    output logic [OCNT_W-1:0]   m_online_count,
    output logic [KEY_W-1:0]    m_key_out,
    output logic [TIME_W-1:0]   m_last_seen_out
);
    typedef enum logic [1:0] {S_IDLE, S_WALK, S_HOLD} state_t;

    state_t              state_reg;
    logic [TIME_W-1:0]   timeout_reg;
    logic [CMD_W-1:0]    cmd_reg;
    logic                sel_ok_reg;
    logic [SLOT_W-1:0]   sel_reg;

    logic [STATUS_W-1:0] res_status_reg;
    logic [RID_W-1:0]    res_rid_reg;
    logic                res_act_reg;
    logic [OCNT_W-1:0]   res_cnt_reg;
    logic [KEY_W-1:0]    res_key_reg;
    logic [TIME_W-1:0]   res_ls_reg;

    logic                m_valid_reg;
    logic [STATUS_W-1:0] m_status_reg;
    logic [RID_W-1:0]    m_rid_reg;
    logic                m_act_reg;
    logic [OCNT_W-1:0]   m_cnt_reg;
    logic [KEY_W-1:0]    m_key_reg;
    logic [TIME_W-1:0]   m_ls_reg;

    nrt_token_t          tok_head;
    nrt_token_t          tok [DEPTH+1];
    logic [DEPTH-1:0]    tok_vld;
    nrt_write_t          wr;

    logic                sel_ok;
    logic [SLOT_W-1:0]   sel;
    logic [ID_W-1:0]     id_m1;
    logic                cfg_wr;
    logic                out_free;

    logic [STATUS_W-1:0] ex_status;
    logic [RID_W-1:0]    ex_rid;
    logic                ex_act;
    logic [OCNT_W-1:0]   ex_cnt;
    logic [KEY_W-1:0]    ex_key;
    logic [TIME_W-1:0]   ex_ls;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite
                    && (paddr[APB_AW-1:2] == REG_TIMEOUT);
    assign prdata = (paddr[APB_AW-1:2] == REG_TIMEOUT) ? timeout_reg : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= TIMEOUT_RESET;
        end else if (cfg_wr) begin
            timeout_reg <= pwdata;
        end
    end

    assign s_ready  = (state_reg == S_IDLE);
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        id_m1  = s_node_id - ID_W'(1);
        sel_ok = 1'b0;
        sel    = '0;
        if ((s_command == CMD_CHECK) || (s_command == CMD_TOUCH)) begin
            sel_ok = (s_node_id != '0) && (s_node_id <= ID_W'(DEPTH));
            sel    = id_m1[SLOT_W-1:0];
        end else if (s_command == CMD_READ) begin
            sel_ok = (s_node_id < ID_W'(DEPTH));
            sel    = s_node_id[SLOT_W-1:0];
        end
    end

    always_comb begin
        tok_head     = '0;
        tok_head.vld = s_valid && s_ready;
        tok_head.key = s_node_key;
        tok_head.now = s_now_ms;
        tok_head.sel = sel;
    end

    assign tok[0] = tok_head;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        nrt_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .cell_idx (SLOT_W'(g)),
            .timeout  (timeout_reg),
            .wr       (wr),
            .tok_in   (tok[g]),
            .tok_out  (tok[g+1])
        );
        assign tok_vld[g] = tok[g+1].vld;
    end

    always_comb begin
        ex_status = STAT_OK;
        ex_rid    = '0;
        ex_act    = 1'b0;
        ex_cnt    = '0;
        ex_key    = '0;
        ex_ls     = '0;
        wr        = '0;
        wr.key    = tok[DEPTH].key;
        wr.now    = tok[DEPTH].now;
        case (cmd_reg)
            CMD_REGISTER: begin
                if (tok[DEPTH].hit) begin
                    ex_rid = slot_to_id(tok[DEPTH].hit_idx);
                end else if (tok[DEPTH].free) begin
                    ex_status    = STAT_ADDED;
                    ex_rid       = slot_to_id(tok[DEPTH].free_idx);
                    wr.en        = (state_reg == S_WALK) && tok[DEPTH].vld;
                    wr.idx       = tok[DEPTH].free_idx;
                    wr.set_valid = 1'b1;
                end else begin
                    ex_status = STAT_MISS;
                end
            end
            CMD_CHECK: begin
                if (sel_ok_reg) begin
                    ex_act = tok[DEPTH].rd_act;
                end else begin
                    ex_status = STAT_INVALID;
                end
            end
            CMD_TOUCH: begin
                if (sel_ok_reg) begin
                    wr.en  = (state_reg == S_WALK) && tok[DEPTH].vld;
                    wr.idx = sel_reg;
                end else begin
                    ex_status = STAT_INVALID;
                end
            end
            CMD_FIND: begin
                if (tok[DEPTH].hit) begin
                    ex_rid = slot_to_id(tok[DEPTH].hit_idx);
                end else begin
                    ex_status = STAT_MISS;
                end
            end
            CMD_COUNT: begin
                ex_cnt = cnt_to_out(tok[DEPTH].cnt);
            end
            CMD_READ: begin
                if (sel_ok_reg) begin
                    ex_act = tok[DEPTH].rd_act;
                    ex_key = tok[DEPTH].rd_key;
                    ex_ls  = tok[DEPTH].rd_ls;
                end else begin
                    ex_status = STAT_INVALID;
                end
            end
            default: begin
                ex_status = STAT_INVALID;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && (state_reg != S_HOLD)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        cmd_reg    <= s_command;
                        sel_ok_reg <= sel_ok;
                        sel_reg    <= sel;
                        state_reg  <= S_WALK;
                    end
                end
                S_WALK: begin
                    if (tok[DEPTH].vld) begin
                        res_status_reg <= ex_status;
                        res_rid_reg    <= ex_rid;
                        res_act_reg    <= ex_act;
                        res_cnt_reg    <= ex_cnt;
                        res_key_reg    <= ex_key;
                        res_ls_reg     <= ex_ls;
                        state_reg      <= S_HOLD;
                    end
                end
                S_HOLD: begin
                    if (out_free) begin
                        m_valid_reg  <= 1'b1;
                        m_status_reg <= res_status_reg;
                        m_rid_reg    <= res_rid_reg;
                        m_act_reg    <= res_act_reg;
                        m_cnt_reg    <= res_cnt_reg;
                        m_key_reg    <= res_key_reg;
                        m_ls_reg     <= res_ls_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_result_id     = m_rid_reg;
    assign m_active_flag   = m_act_reg;
    assign m_online_count  = m_cnt_reg;
    assign m_key_out       = m_key_reg;
    assign m_last_seen_out = m_ls_reg;

    `NRT_ASSERT(a_one_item_in_chain, $countones(tok_vld) <= 1,
        "More than one item in the chain.")
    `NRT_ASSERT_NEXT(a_accept_enters_chain, s_valid && s_ready, tok[1].vld,
        "Accepted item did not enter the chain.")
    `NRT_ASSERT(a_idle_chain_empty, (state_reg == S_IDLE) |-> (tok_vld == '0),
        "Chain busy while idle.")
    `NRT_ASSERT(a_invalid_fields_zero, (m_valid && (m_status == STAT_INVALID)) |->
        ((m_result_id == '0) && (m_online_count == '0) && (m_key_out == '0)
        && (m_last_seen_out == '0) && !m_active_flag), "Invalid result carries data.")
endmodule
`default_nettype wire
